FILE: hw/rtl/ipv6_mdns_forward_filter_top_macros.svh
// Assertion macros for the checker file of the mDNS forward filter.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef IPV6_MDNS_FORWARD_FILTER_TOP_MACROS_SVH
`define IPV6_MDNS_FORWARD_FILTER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MDNSFF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MDNSFF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hw/rtl/mdnsff_pkg.sv
// Package for the IPv6 mDNS forward filter: verdict types, header constants
// and small lookup functions. No dependencies.
package mdnsff_pkg;

    // Drop reason codes as carried on the result channel.
    typedef enum logic [2:0] {
        REASON_PASS        = 3'd0,
        REASON_SHORT       = 3'd1,
        REASON_NOT_IPV6    = 3'd2,
        REASON_NOT_UDP     = 3'd3,
        REASON_PORT        = 3'd4,
        REASON_DST_GROUP   = 3'd5,
        REASON_LINK_LOCAL  = 3'd6,
        REASON_NOT_ULA_GUA = 3'd7
    } reason_t;

    // One verdict as handed from the parser to the output stage.
    typedef struct packed {
        logic    forward;
        reason_t reason;
        logic    toward_wireless;
    } verdict_t;

    // Header layout and field values.
    localparam logic [5:0] MinLen        = 6'd48;
    localparam logic [5:0] PosNextHeader = 6'd6;
    localparam logic [5:0] PosSrcHi      = 6'd8;
    localparam logic [5:0] PosSrcLo      = 6'd9;
    localparam logic [5:0] PosDstFirst   = 6'd24;
    localparam logic [5:0] PosDstHi      = 6'd24;
    localparam logic [5:0] PosDstLo      = 6'd25;
    localparam logic [5:0] PosDstLast    = 6'd39;
    localparam logic [5:0] PosPortFirst  = 6'd40;
    localparam logic [5:0] PosPortLast   = 6'd43;
    localparam logic [3:0] IpVersion     = 4'h6;
    localparam logic [7:0] UdpProto      = 8'd17;
    localparam logic [15:0] LinkLocal    = 16'hfe80;
    localparam logic [15:0] DefaultMdnsPort = 16'd5353;

    // Byte of the mDNS group address ff02::fb at the given offset.
    function automatic logic [7:0] group_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hff;
            4'd1:    b = 8'h02;
            4'd15:   b = 8'hfb;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Classify an address by its first 16 bits: ULA or global passes.
    function automatic reason_t classify(input logic [15:0] prefix);
        reason_t r;
        if (prefix == LinkLocal) begin
            r = REASON_LINK_LOCAL;
        end else if (prefix[15:9] == 7'b1111110 || prefix[15:13] == 3'b001) begin
            r = REASON_PASS;
        end else begin
            r = REASON_NOT_ULA_GUA;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/mdnsff_parser.sv
// Per-packet header tracker of the mDNS forward filter: collects the header
// fields byte by byte and forms the verdict on the last byte. Uses mdnsff_pkg.
module mdnsff_parser import mdnsff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_en,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        from_host_side,
    input  logic [15:0] mdns_port,
    output verdict_t    verdict
);

    logic [5:0]  pos_reg, pos_next;
    logic        dir_reg, dir_next;
    logic        ver_ok_reg, ver_ok_next;
    logic        nh_ok_reg, nh_ok_next;
    logic [15:0] src_prefix_reg, src_prefix_next;
    logic [15:0] dst_prefix_reg, dst_prefix_next;
    logic        dst_group_reg, dst_group_next;
    logic [31:0] port_pair_reg, port_pair_next;

    logic        first_beat;
    logic [3:0]  group_idx;
    reason_t     reason;

    assign first_beat = (pos_reg == 6'd0);
    // Offset into ff02::fb; position 24 has low bits 8, so this wraps to 0.
    assign group_idx  = pos_reg[3:0] - 4'd8;

    // Field capture for the beat being accepted, then clear after the last byte.
    always_comb begin
        pos_next        = pos_reg;
        dir_next        = dir_reg;
        ver_ok_next     = ver_ok_reg;
        nh_ok_next      = nh_ok_reg;
        src_prefix_next = src_prefix_reg;
        dst_prefix_next = dst_prefix_reg;
        dst_group_next  = dst_group_reg;
        port_pair_next  = port_pair_reg;
        if (beat_en) begin
            if (first_beat) begin
                dir_next    = from_host_side;
                ver_ok_next = (data_byte[7:4] == IpVersion);
            end
            if (pos_reg == PosNextHeader) begin
                nh_ok_next = (data_byte == UdpProto);
            end
            if (pos_reg == PosSrcHi || pos_reg == PosSrcLo) begin
                src_prefix_next = {src_prefix_reg[7:0], data_byte};
            end
            if (pos_reg >= PosDstFirst && pos_reg <= PosDstLast) begin
                if (data_byte != group_byte(group_idx)) begin
                    dst_group_next = 1'b0;
                end
            end
            if (pos_reg == PosDstHi || pos_reg == PosDstLo) begin
                dst_prefix_next = {dst_prefix_reg[7:0], data_byte};
            end
            if (pos_reg >= PosPortFirst && pos_reg <= PosPortLast) begin
                port_pair_next = {port_pair_reg[23:0], data_byte};
            end
            if (pos_reg < MinLen) begin
                pos_next = pos_reg + 6'd1;
            end
            if (last_byte) begin
                pos_next        = 6'd0;
                ver_ok_next     = 1'b0;
                nh_ok_next      = 1'b0;
                src_prefix_next = 16'd0;
                dst_prefix_next = 16'd0;
                dst_group_next  = 1'b1;
                port_pair_next  = 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 6'd0;
            dir_reg        <= 1'b0;
            ver_ok_reg     <= 1'b0;
            nh_ok_reg      <= 1'b0;
            src_prefix_reg <= 16'd0;
            dst_prefix_reg <= 16'd0;
            dst_group_reg  <= 1'b1;
            port_pair_reg  <= 32'd0;
        end else begin
            pos_reg        <= pos_next;
            dir_reg        <= dir_next;
            ver_ok_reg     <= ver_ok_next;
            nh_ok_reg      <= nh_ok_next;
            src_prefix_reg <= src_prefix_next;
            dst_prefix_reg <= dst_prefix_next;
            dst_group_reg  <= dst_group_next;
            port_pair_reg  <= port_pair_next;
        end
    end

    // Verdict for a last byte. A packet that is long enough ends at position
    // 47 or later, so every header field is already in its register then.
    always_comb begin
        if (pos_reg < MinLen - 6'd1) begin
            reason = REASON_SHORT;
        end else if (!ver_ok_reg) begin
            reason = REASON_NOT_IPV6;
        end else if (!nh_ok_reg) begin
            reason = REASON_NOT_UDP;
        end else if (port_pair_reg[31:16] != mdns_port &&
                     port_pair_reg[15:0] != mdns_port) begin
            reason = REASON_PORT;
        end else if (dir_reg) begin
            reason = dst_group_reg ? classify(src_prefix_reg) : REASON_DST_GROUP;
        end else begin
            reason = dst_group_reg ? REASON_PASS : classify(dst_prefix_reg);
        end
    end

    assign verdict.forward         = (reason == REASON_PASS);
    assign verdict.reason          = reason;
    assign verdict.toward_wireless = first_beat ? from_host_side : dir_reg;

endmodule

FILE: hw/rtl/ipv6_mdns_forward_filter_top.sv
// IPv6 mDNS forward filter: top level with the port register and the result
// register. Uses mdnsff_pkg and mdnsff_parser.
//
// Usage: an IPv6 packet enters one byte per beat on the s_ channel, header
// first, with s_last_byte set on its final byte and s_from_host_side giving
// the direction on the first byte. Each packet yields exactly one result beat
// on the m_ channel: m_forward, the drop reason in m_reason (zero on pass) and
// the direction in m_toward_wireless. Bytes other than the last yield nothing.
// The result appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle unless a result stalls in the single result
// register; a new packet may start right after the previous one's last byte.
// The user must write the mDNS port via cfg_we and cfg_wdata while the block
// idles; the block does not enforce it. Reset clears all packet state, empties
// the result register and sets the port to 5353. When the receiver stalls with
// a result pending, s_ready drops and input beats wait until it is taken.
module ipv6_mdns_forward_filter_top import mdnsff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        s_from_host_side,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_forward,
    output logic [2:0]  m_reason,
    output logic        m_toward_wireless,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] mdns_port_reg;
    logic        m_valid_reg, m_valid_next;
    verdict_t    verdict_reg;
    verdict_t    verdict;
    logic        beat_en;

    assign s_ready = !m_valid_reg || m_ready;
    assign beat_en = s_valid && s_ready;

    // Port register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mdns_port_reg <= DefaultMdnsPort;
        end else if (cfg_we) begin
            mdns_port_reg <= cfg_wdata;
        end
    end

    mdnsff_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .beat_en        (beat_en),
        .data_byte      (s_data_byte),
        .last_byte      (s_last_byte),
        .from_host_side (s_from_host_side),
        .mdns_port      (mdns_port_reg),
        .verdict        (verdict)
    );

    // Result register: filled by a last byte, emptied when the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (beat_en && s_last_byte) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_en && s_last_byte) begin
            verdict_reg <= verdict;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_forward         = verdict_reg.forward;
    assign m_reason          = verdict_reg.reason;
    assign m_toward_wireless = verdict_reg.toward_wireless;

endmodule

FILE: hw/rtl/mdnsff_checker.sv
// Port-level checker for the IPv6 mDNS forward filter, bound to the top level.
// Uses mdnsff_pkg and the macros in ipv6_mdns_forward_filter_top_macros.svh.
`include "ipv6_mdns_forward_filter_top_macros.svh"

module mdnsff_checker import mdnsff_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_forward,
    input logic [2:0]  m_reason,
    input logic        m_toward_wireless
);

    // A stalled result beat keeps its payload.
    `MDNSFF_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_forward) && $stable(m_reason) && $stable(m_toward_wireless), "result beat changed while stalled")

    // Forward is set exactly for the pass code.
    `MDNSFF_ASSERT(a_forward_code, m_valid |-> (m_forward == (m_reason == REASON_PASS)), "forward flag disagrees with reason")

    // Every accepted last byte gives a result in the next cycle.
    `MDNSFF_ASSERT(a_last_gives_result, s_valid && s_ready && s_last_byte |=> m_valid, "last byte gave no result")

    // A byte that is not the last never produces a result.
    `MDNSFF_ASSERT(a_no_extra_result, s_valid && s_ready && !s_last_byte |=> !m_valid, "result without a last byte")

    // Reset leaves the result channel empty.
    `MDNSFF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind ipv6_mdns_forward_filter_top mdnsff_checker u_checker (.*);
